// ===== design/buddy_tree_page_allocator_top_macros.svh =====
// Assertion helpers shared by the allocator RTL.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef BUDDY_TREE_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_TREE_PAGE_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTPA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/btpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package btpa_pkg;

  // Tree geometry.
  localparam int PAGES      = 1024;
  localparam int LOG_PAGES  = $clog2(PAGES);
  localparam int NODE_W     = LOG_PAGES + 1;
  localparam int TREE_DEPTH = 2 * PAGES;

  // Transaction field widths.
  localparam int OP_W     = 2;
  localparam int COUNT_W  = 11;
  localparam int OFF_W    = 10;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 11;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DL,
    S_DLW,
    S_DRW,
    S_MARK,
    S_FR,
    S_FRW,
    S_UPW,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [SIZE_W-1:0] wdata;
    logic [NODE_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFF_W-1:0]    block_offset;
    logic [SIZE_W-1:0]   block_size;
    logic [SIZE_W-1:0]   largest_free;
  } res_t;

endpackage

`default_nettype wire

// ===== design/btpa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Request channel.
interface btpa_in_if;
  logic                         valid;
  logic                         ready;
  logic [btpa_pkg::OP_W-1:0]    op;
  logic [btpa_pkg::COUNT_W-1:0] page_count;
  logic [btpa_pkg::OFF_W-1:0]   page_offset;

  modport source (output valid, op, page_count, page_offset, input ready);
  modport sink (input valid, op, page_count, page_offset, output ready);
endinterface

// Response channel.
interface btpa_out_if;
  logic                          valid;
  logic                          ready;
  logic [btpa_pkg::STATUS_W-1:0] status;
  logic [btpa_pkg::OFF_W-1:0]    block_offset;
  logic [btpa_pkg::SIZE_W-1:0]   block_size;
  logic [btpa_pkg::SIZE_W-1:0]   largest_free;

  modport source (output valid, status, block_offset, block_size, largest_free,
                  input ready);
  modport sink (input valid, status, block_offset, block_size, largest_free,
                output ready);
endinterface

`default_nettype wire

// ===== design/btpa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module btpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/btpa_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_tree_page_allocator_top_macros.svh"

// Sequencer that walks the free-size tree through the tree memory.
module btpa_engine (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  btpa_in_if.sink                           in_chan,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output btpa_pkg::res_t                    res,
  output btpa_pkg::mem_req_t                mem_req,
  input  wire logic [btpa_pkg::SIZE_W-1:0]  mem_rdata
);

  localparam int NW = btpa_pkg::NODE_W;
  localparam int SW = btpa_pkg::SIZE_W;
  localparam int OW = btpa_pkg::OFF_W;

  btpa_pkg::state_t state_r, state_nxt;

  logic [NW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [SW-1:0] clr_val_r, clr_val_nxt;
  logic [SW-1:0] root_r, root_nxt;
  logic [SW-1:0] need_r, need_nxt;
  logic [NW-1:0] node_r, node_nxt;
  logic [SW-1:0] size_r, size_nxt;
  logic [OW-1:0] off_r, off_nxt;
  logic [SW-1:0] cur_val_r, cur_val_nxt;
  logic [SW-1:0] child_val_r, child_val_nxt;
  btpa_pkg::status_t status_r, status_nxt;
  logic [SW-1:0] bsize_r, bsize_nxt;
  logic [OW-1:0] boff_r, boff_nxt;

  logic          in_ready;
  logic          in_fire;
  logic [SW-1:0] in_need;
  logic          node_is_root;
  logic [NW-1:0] left_node;
  logic [NW-1:0] right_node;
  logic [NW-1:0] parent_node;
  logic          left_fits;
  logic          right_fits;
  logic [SW-1:0] parent_size;
  logic [SW:0]   pair_sum;
  logic [SW-1:0] pair_max;
  logic [SW-1:0] merged_val;
  logic          parent_is_root;
  logic [NW-1:0] clr_cnt_inc;

  assign in_chan.ready = in_ready;
  assign in_fire       = in_chan.valid && in_ready;
  assign in_need       = (in_chan.page_count == '0) ? SW'(1) : in_chan.page_count;

  assign node_is_root   = (node_r == NW'(1));
  assign left_node      = {node_r[NW-2:0], 1'b0};
  assign right_node     = {node_r[NW-2:0], 1'b1};
  assign parent_node    = node_r >> 1;
  assign parent_is_root = (parent_node == NW'(1));
  assign left_fits      = (mem_rdata >= need_r);
  assign right_fits     = (mem_rdata >= need_r);

  // Merge rule: two wholly free halves rejoin into one block.
  assign parent_size = size_r << 1;
  assign pair_sum    = {1'b0, child_val_r} + {1'b0, mem_rdata};
  assign pair_max    = (child_val_r > mem_rdata) ? child_val_r : mem_rdata;
  assign merged_val  = (pair_sum == {1'b0, parent_size}) ? parent_size : pair_max;
  assign clr_cnt_inc = clr_cnt_r + NW'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      btpa_pkg::S_CLEAR: begin
        if (clr_cnt_r == NW'(btpa_pkg::TREE_DEPTH - 1)) begin
          state_nxt = btpa_pkg::S_IDLE;
        end
      end
      btpa_pkg::S_IDLE: begin
        if (in_fire) begin
          priority if (in_chan.op == btpa_pkg::OP_ALLOC) begin
            state_nxt = (in_need > root_r) ? btpa_pkg::S_DONE : btpa_pkg::S_DL;
          end else if (in_chan.op == btpa_pkg::OP_FREE) begin
            state_nxt = ({1'b0, in_chan.page_offset} >= NW'(btpa_pkg::PAGES))
                        ? btpa_pkg::S_DONE : btpa_pkg::S_FR;
          end else begin
            state_nxt = btpa_pkg::S_DONE;
          end
        end
      end
      btpa_pkg::S_DL:  state_nxt = btpa_pkg::S_DLW;
      btpa_pkg::S_DLW: begin
        if (left_fits) begin
          state_nxt = left_node[NW-1] ? btpa_pkg::S_MARK : btpa_pkg::S_DL;
        end else begin
          state_nxt = btpa_pkg::S_DRW;
        end
      end
      btpa_pkg::S_DRW: begin
        if (right_fits && !right_node[NW-1]) begin
          state_nxt = btpa_pkg::S_DL;
        end else begin
          state_nxt = btpa_pkg::S_MARK;
        end
      end
      btpa_pkg::S_MARK: state_nxt = node_is_root ? btpa_pkg::S_DONE : btpa_pkg::S_UPW;
      btpa_pkg::S_FR:   state_nxt = btpa_pkg::S_FRW;
      btpa_pkg::S_FRW: begin
        priority if (mem_rdata == '0) begin
          state_nxt = node_is_root ? btpa_pkg::S_DONE : btpa_pkg::S_UPW;
        end else if (node_is_root) begin
          state_nxt = btpa_pkg::S_DONE;
        end else begin
          state_nxt = btpa_pkg::S_FR;
        end
      end
      btpa_pkg::S_UPW: state_nxt = parent_is_root ? btpa_pkg::S_DONE : btpa_pkg::S_UPW;
      btpa_pkg::S_DONE: begin
        if (res_ready) begin
          state_nxt = btpa_pkg::S_IDLE;
        end
      end
      default: state_nxt = btpa_pkg::S_IDLE;
    endcase
  end

  // Memory requests and handshake outputs.
  always_comb begin
    mem_req   = '0;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      btpa_pkg::S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_cnt_r;
        mem_req.wdata = (clr_cnt_r == '0) ? '0 : clr_val_r;
      end
      btpa_pkg::S_IDLE: in_ready = 1'b1;
      btpa_pkg::S_DL:   mem_req.raddr = left_node;
      btpa_pkg::S_DLW:  mem_req.raddr = right_node;
      btpa_pkg::S_DRW:  mem_req.raddr = '0;
      btpa_pkg::S_MARK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = node_r;
        mem_req.wdata = '0;
        mem_req.raddr = node_r ^ NW'(1);
      end
      btpa_pkg::S_FR:  mem_req.raddr = node_r;
      btpa_pkg::S_FRW: begin
        if (mem_rdata == '0) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = node_r;
          mem_req.wdata = size_r;
          mem_req.raddr = node_r ^ NW'(1);
        end
      end
      btpa_pkg::S_UPW: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = parent_node;
        mem_req.wdata = merged_val;
        mem_req.raddr = parent_node ^ NW'(1);
      end
      btpa_pkg::S_DONE: res_valid = 1'b1;
      default: mem_req = '0;
    endcase
  end

  // Datapath updates.
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    clr_val_nxt   = clr_val_r;
    root_nxt      = root_r;
    need_nxt      = need_r;
    node_nxt      = node_r;
    size_nxt      = size_r;
    off_nxt       = off_r;
    cur_val_nxt   = cur_val_r;
    child_val_nxt = child_val_r;
    status_nxt    = status_r;
    bsize_nxt     = bsize_r;
    boff_nxt      = boff_r;
    unique case (state_r)
      btpa_pkg::S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_inc;
        // Each new tree level starts after an index of the form 2^k - 1.
        if (clr_cnt_r != '0 && (clr_cnt_inc & clr_cnt_r) == '0) begin
          clr_val_nxt = clr_val_r >> 1;
        end
      end
      btpa_pkg::S_IDLE: begin
        if (in_fire) begin
          status_nxt  = btpa_pkg::ST_OK;
          bsize_nxt   = '0;
          boff_nxt    = '0;
          need_nxt    = in_need;
          node_nxt    = NW'(1);
          size_nxt    = SW'(btpa_pkg::PAGES);
          off_nxt     = '0;
          cur_val_nxt = root_r;
          priority if (in_chan.op == btpa_pkg::OP_ALLOC) begin
            if (in_need > root_r) begin
              status_nxt = btpa_pkg::ST_NOFIT;
            end
          end else if (in_chan.op == btpa_pkg::OP_FREE) begin
            if ({1'b0, in_chan.page_offset} >= NW'(btpa_pkg::PAGES)) begin
              status_nxt = btpa_pkg::ST_BADFREE;
            end
            node_nxt = NW'(btpa_pkg::PAGES) + NW'(in_chan.page_offset);
            size_nxt = SW'(1);
          end else begin
            status_nxt = btpa_pkg::ST_OK;
          end
        end
      end
      btpa_pkg::S_DL: need_nxt = need_r;
      btpa_pkg::S_DLW: begin
        if (left_fits) begin
          node_nxt    = left_node;
          size_nxt    = size_r >> 1;
          cur_val_nxt = mem_rdata;
        end
      end
      btpa_pkg::S_DRW: begin
        if (right_fits) begin
          node_nxt    = right_node;
          size_nxt    = size_r >> 1;
          off_nxt     = off_r + OW'(size_r >> 1);
          cur_val_nxt = mem_rdata;
        end
      end
      btpa_pkg::S_MARK: begin
        bsize_nxt     = cur_val_r;
        boff_nxt      = off_r;
        child_val_nxt = '0;
        if (node_is_root) begin
          root_nxt = '0;
        end
      end
      btpa_pkg::S_FR: node_nxt = node_r;
      btpa_pkg::S_FRW: begin
        priority if (mem_rdata == '0) begin
          bsize_nxt     = size_r;
          child_val_nxt = size_r;
          if (node_is_root) begin
            root_nxt = size_r;
          end
        end else if (node_is_root) begin
          status_nxt = btpa_pkg::ST_BADFREE;
        end else begin
          node_nxt = parent_node;
          size_nxt = size_r << 1;
        end
      end
      btpa_pkg::S_UPW: begin
        node_nxt      = parent_node;
        size_nxt      = parent_size;
        child_val_nxt = merged_val;
        if (parent_is_root) begin
          root_nxt = merged_val;
        end
      end
      btpa_pkg::S_DONE: boff_nxt = boff_r;
      default: clr_cnt_nxt = clr_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= btpa_pkg::S_CLEAR;
      clr_cnt_r <= '0;
      clr_val_r <= SW'(btpa_pkg::PAGES);
      root_r    <= SW'(btpa_pkg::PAGES);
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      clr_val_r <= clr_val_nxt;
      root_r    <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    need_r      <= need_nxt;
    node_r      <= node_nxt;
    size_r      <= size_nxt;
    off_r       <= off_nxt;
    cur_val_r   <= cur_val_nxt;
    child_val_r <= child_val_nxt;
    status_r    <= status_nxt;
    bsize_r     <= bsize_nxt;
    boff_r      <= boff_nxt;
  end

  assign res.status       = status_r;
  assign res.block_offset = boff_r;
  assign res.block_size   = bsize_r;
  assign res.largest_free = root_r;

  // A node is never rewritten in the cycle its own value is fetched.
  `BTPA_ASSERT_NOW(a_no_rw_collision,
    mem_req.we && state_r != btpa_pkg::S_CLEAR,
    mem_req.waddr != mem_req.raddr,
    "tree write and read hit the same node")

  // The block size tracked during a walk is always a power of two.
  `BTPA_ASSERT_NOW(a_size_pow2,
    state_r == btpa_pkg::S_DL || state_r == btpa_pkg::S_DLW ||
    state_r == btpa_pkg::S_DRW || state_r == btpa_pkg::S_MARK ||
    state_r == btpa_pkg::S_FR || state_r == btpa_pkg::S_FRW ||
    state_r == btpa_pkg::S_UPW,
    $onehot(size_r),
    "walk size is not a power of two")

  // A rejected allocation really exceeded the largest free block.
  `BTPA_ASSERT_NOW(a_nofit_consistent,
    res_valid && status_r == btpa_pkg::ST_NOFIT,
    need_r > root_r,
    "allocation rejected although it fits")

  // Every granted or released block is a power of two in size.
  `BTPA_ASSERT_NOW(a_block_pow2,
    res_valid && status_r == btpa_pkg::ST_OK && bsize_r != '0,
    $onehot(bsize_r),
    "block size is not a power of two")

  // The sequencer leaves idle only on an accepted transaction.
  `BTPA_ASSERT_NEXT(a_idle_holds,
    state_r == btpa_pkg::S_IDLE && !in_fire,
    state_r == btpa_pkg::S_IDLE,
    "sequencer left idle without a transaction")

endmodule

`default_nettype wire

// ===== design/buddy_tree_page_allocator_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Buddy page allocator for 1024 pages, kept as a complete binary tree of free
// sizes in one 2048 x 11 synchronous tree memory. Each request transaction is
// an allocate (op 0), a free (op 1) or a query (op 2 or 3), and gives exactly
// one response transaction with a status, the block offset and size, and the
// largest free block remaining. After reset the block writes the all-free tree
// into the memory, one node per cycle, before it raises in_chan.ready. Each
// transaction passes through the sequencer's done state and then loads the
// output register before its response is offered. A query or an allocate that
// does not fit goes straight to the done state. An allocate first walks down
// the tree (10 levels at most), reading the left child at each level and the
// right child as well where the left does not fit, then marks the block and
// updates each ancestor. A free reads each node on the way from the page's
// leaf up to and including the allocated node, then updates each ancestor; a
// free of a page with no allocated block above it reads all 11 nodes up to the
// root. The single read port of the tree memory shapes these walks: every
// level of a walk needs its own read.
// One transaction is in flight at a time, but a finished response waits in the
// output register so the next request can be accepted while it is unclaimed.
module buddy_tree_page_allocator_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  btpa_in_if.sink    in_chan,
  btpa_out_if.source out_chan
);

  // Engine to output register.
  logic               res_valid;
  logic               res_ready;
  btpa_pkg::res_t     res;

  // Tree memory access.
  btpa_pkg::mem_req_t                mem_req;
  logic [btpa_pkg::SIZE_W-1:0]       mem_rdata;

  // Response holding register.
  logic           out_valid_r, out_valid_nxt;
  btpa_pkg::res_t out_res_r, out_res_nxt;

  btpa_ram #(
    .WIDTH (btpa_pkg::SIZE_W),
    .DEPTH (btpa_pkg::TREE_DEPTH)
  ) u_tree_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  btpa_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  // The register takes a new response whenever it is empty or being drained.
  assign res_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_res_r.status;
  assign out_chan.block_offset = out_res_r.block_offset;
  assign out_chan.block_size   = out_res_r.block_size;
  assign out_chan.largest_free = out_res_r.largest_free;

endmodule

`default_nettype wire
